FILE: rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the processing element pool with countdown.
// ----------------------------------------------------------------------------
package ppc_pkg;

    // default sizing
    localparam int NUM_PE_DEFAULT     = 8;
    localparam int COUNT_BITS_DEFAULT = 16;

    // field widths
    localparam int PE_W     = 3;
    localparam int TASK_W   = 16;
    localparam int MOD_W    = 8;
    localparam int EXEC_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 4;
    localparam int MAX_TICK = 8;   // elements that pe_index can address

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 64;

    // s_tdata layout
    localparam int S_PE_LO   = 0;
    localparam int S_TASK_LO = S_PE_LO + PE_W;
    localparam int S_MOD_LO  = S_TASK_LO + TASK_W;
    localparam int S_EXEC_LO = S_MOD_LO + MOD_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } ppc_state_t;

    typedef struct packed {
        logic accept;  // input beat taken this cycle
        logic scan;    // pick next completion and start its table read
        logic emit;    // load the output register
    } ppc_cmd_t;

    typedef struct packed {
        logic is_load;   // offered beat is a load
        logic tick_hit;  // offered tick would finish at least one element
        logic pend_any;  // completions still waiting
        logic out_free;  // output register can take a beat
    } ppc_stat_t;

endpackage

FILE: rtl/ppc_ram.sv
// ----------------------------------------------------------------------------
// ppc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// Sequencer: takes one beat, then walks the completions one table read each.
// ----------------------------------------------------------------------------
module ppc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ppc_pkg::ppc_stat_t stat,
    output ppc_pkg::ppc_cmd_t  cmd
);
    import ppc_pkg::*;

    ppc_state_t state_reg;
    ppc_state_t state_next;
    logic       accept;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cmd.accept = accept;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.emit   = (state_reg == ST_EMIT) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (stat.is_load) begin
                        state_next = ST_EMIT;
                    end else if (stat.tick_hit) begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = stat.pend_any ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ppc_datapath.sv
// ----------------------------------------------------------------------------
// ppc_datapath
// Element counters, tick timer, completion mask, task table and output beat.
// ----------------------------------------------------------------------------
module ppc_datapath #(
    parameter int NUM_PE     = ppc_pkg::NUM_PE_DEFAULT,
    parameter int COUNT_BITS = ppc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ppc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ppc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [ppc_pkg::CFG_W-1:0]       cfg_wr_data,
    input  ppc_pkg::ppc_cmd_t               cmd,
    output ppc_pkg::ppc_stat_t              stat
);
    import ppc_pkg::*;

    localparam int IDX_W  = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;
    localparam int MASK_N = (NUM_PE < MAX_TICK) ? NUM_PE : MAX_TICK;
    localparam int ENT_W  = MOD_W + TASK_W;
    localparam int PAD_W  = M_TDATA_W - (1 + PE_W + TASK_W + MOD_W + TIME_W);

    // input fields
    logic [PE_W-1:0]   pe_in;
    logic [TASK_W-1:0] task_in;
    logic [MOD_W-1:0]  mod_in;
    logic [EXEC_W-1:0] exec_in;
    logic              is_load;

    logic [IDX_W-1:0]  pe_idx;
    logic              pe_ok;
    logic              pe_busy;
    logic              load_acc;
    logic              tick_acc;
    logic              ld_wr;

    logic [CFG_W-1:0]      active_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [NUM_PE-1:0]     busy_reg;
    logic [COUNT_BITS-1:0] cnt_reg [NUM_PE];
    logic [NUM_PE-1:0]     dec;
    logic [NUM_PE-1:0]     fin;
    logic [MASK_N-1:0]     hit;
    logic [MASK_N-1:0]     mask_reg;
    logic [PE_W-1:0]       pick;

    // pending result
    logic              res_kind_reg;
    logic              res_status_reg;
    logic [PE_W-1:0]   res_pe_reg;
    logic [TASK_W-1:0] res_task_reg;
    logic [MOD_W-1:0]  res_mod_reg;
    logic              res_use_ram_reg;

    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [TASK_W-1:0] out_task;
    logic [MOD_W-1:0]  out_mod;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;
    logic                 out_free;

    assign pe_in   = s_tdata[S_PE_LO +: PE_W];
    assign task_in = s_tdata[S_TASK_LO +: TASK_W];
    assign mod_in  = s_tdata[S_MOD_LO +: MOD_W];
    assign exec_in = s_tdata[S_EXEC_LO +: EXEC_W];
    assign is_load = (s_tuser == REQ_LOAD);

    assign pe_ok    = (32'(pe_in) < NUM_PE);
    assign pe_idx   = IDX_W'(pe_in);
    assign pe_busy  = pe_ok && busy_reg[pe_idx];
    assign load_acc = cmd.accept && is_load;
    assign tick_acc = cmd.accept && !is_load;
    assign ld_wr    = load_acc && pe_ok && !pe_busy;

    // one countdown lane per element
    for (genvar i = 0; i < NUM_PE; i++) begin : g_pe
        logic ticked;
        assign ticked = (i < MAX_TICK) && (32'(active_reg) > i);
        assign dec[i] = ticked && busy_reg[i] && (cnt_reg[i] != '0);
        assign fin[i] = dec[i] && (cnt_reg[i] == COUNT_BITS'(1));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                busy_reg[i] <= 1'b0;
                cnt_reg[i]  <= '0;
            end else if (tick_acc && dec[i]) begin
                cnt_reg[i] <= cnt_reg[i] - COUNT_BITS'(1);
                if (fin[i]) begin
                    busy_reg[i] <= 1'b0;
                end
            end else if (ld_wr && (pe_idx == IDX_W'(i))) begin
                busy_reg[i] <= 1'b1;
                cnt_reg[i]  <= COUNT_BITS'(exec_in);
            end
        end
    end

    assign hit = fin[MASK_N-1:0];

    // lowest pending element goes first
    always_comb begin
        pick = '0;
        for (int i = MASK_N - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pick = PE_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
            time_reg   <= '0;
            mask_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
            if (tick_acc) begin
                time_reg <= time_reg + TIME_W'(1);
                mask_reg <= hit;
            end else if (cmd.scan) begin
                mask_reg <= mask_reg & ~(MASK_N'(1) << pick);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            res_kind_reg    <= KIND_ACK;
            res_status_reg  <= (pe_ok && !pe_busy) ? STATUS_OK : STATUS_REFUSED;
            res_pe_reg      <= pe_in;
            res_task_reg    <= pe_ok ? task_in : '0;
            res_mod_reg     <= pe_ok ? mod_in : '0;
            res_use_ram_reg <= pe_busy;
        end else if (cmd.scan) begin
            res_kind_reg    <= KIND_DONE;
            res_status_reg  <= STATUS_OK;
            res_pe_reg      <= pick;
            res_use_ram_reg <= 1'b1;
        end
    end

    // task and module held per element
    assign ram_re    = (load_acc && pe_busy) || cmd.scan;
    assign ram_raddr = cmd.scan ? IDX_W'(pick) : pe_idx;

    ppc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PE)
    ) u_task_ram (
        .aclk  (aclk),
        .we    (ld_wr),
        .waddr (pe_idx),
        .wdata ({mod_in, task_in}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_task = res_use_ram_reg ? ram_rdata[TASK_W-1:0] : res_task_reg;
    assign out_mod  = res_use_ram_reg ? ram_rdata[ENT_W-1:TASK_W] : res_mod_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, time_reg, out_mod, out_task,
                            res_pe_reg, res_status_reg};
            m_tuser_reg <= res_kind_reg;
            m_tlast_reg <= (mask_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat.is_load  = is_load;
    assign stat.tick_hit = (hit != '0);
    assign stat.pend_any = (mask_reg != '0);
    assign stat.out_free = out_free;

endmodule

FILE: rtl/processing_element_pool_countdown_top.sv
// ----------------------------------------------------------------------------
// processing_element_pool_countdown_top
// Pool of processing elements counted down by tick beats, loaded by load beats.
// ----------------------------------------------------------------------------
// A load beat is accepted in IDLE, and EMIT then fills the output register.
// A tick beat that finishes no element stays in IDLE; a tick that finishes
// elements passes SCAN and then EMIT for each completion, since each needs one read
// of the task table (one read port) before its beat goes out. Every element below
// the active count and MAX_TICK is counted down in parallel in the accept cycle.
// A stalled m_tready holds EMIT only once the output register is full; the next
// input beat is taken while a result still waits there.
module processing_element_pool_countdown_top #(
    parameter int NUM_PE     = ppc_pkg::NUM_PE_DEFAULT,
    parameter int COUNT_BITS = ppc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pe_index[2:0], task_id[18:3], module_id[26:19], exec_count[42:27], zeros
    input  logic [ppc_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // load_status[0], done_pe[3:1], done_task[19:4], done_module[27:20],
    // time_stamp[59:28], zeros
    output logic [ppc_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_wr_en,
    input  logic [ppc_pkg::CFG_W-1:0]     cfg_wr_data
);
    import ppc_pkg::*;

    ppc_cmd_t  cmd;
    ppc_stat_t stat;

    ppc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppc_datapath #(
        .NUM_PE     (NUM_PE),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the processing element pool with countdown. Load and
// tick beats go in on the slave stream while a scoreboard class tracks every
// element, the tick timer and the active count, and predicts each result beat.
// Result beats are compared in order, field by field. The run covers directed
// corner cases, random traffic under several active counts, a long output
// stall and a final flush of every pending countdown.
// ----------------------------------------------------------------------------
module tb_top;
    import ppc_pkg::*;

    localparam int NPE           = NUM_PE_DEFAULT;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    // m_tdata layout
    localparam int M_STATUS_LO = 0;
    localparam int M_PE_LO     = 1;
    localparam int M_TASK_LO   = 4;
    localparam int M_MOD_LO    = 20;
    localparam int M_TIME_LO   = 28;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [PE_W-1:0]   pe;
        logic [TASK_W-1:0] done_task;
        logic [MOD_W-1:0]  done_module;
        logic [TIME_W-1:0] stamp;
        logic              last;
    } pool_result_t;

    class pool_scoreboard;
        logic              busy       [NPE];
        logic [EXEC_W-1:0] ticks_left [NPE];
        logic [MOD_W-1:0]  held_mod   [NPE];
        logic [TASK_W-1:0] held_id    [NPE];
        logic [TIME_W-1:0] tick_now;
        logic [CFG_W-1:0]  active_pes;
        pool_result_t      due_results[$];
        int errors, beats, acks, refusals, completions;

        function new();
            for (int i = 0; i < NPE; i++) begin
                busy[i]       = 1'b0;
                ticks_left[i] = '0;
                held_mod[i]   = '0;
                held_id[i]    = '0;
            end
            tick_now    = '0;
            active_pes  = ACTIVE_RESET;
            errors      = 0;
            beats       = 0;
            acks        = 0;
            refusals    = 0;
            completions = 0;
        endfunction

        // work out the result beats that one accepted input beat causes
        function void note_beat(logic req, logic [S_TDATA_W-1:0] data);
            logic [PE_W-1:0]   pe;
            logic [TASK_W-1:0] id;
            logic [MOD_W-1:0]  md;
            logic [EXEC_W-1:0] cnt;
            int                span;
            int                first;
            pool_result_t      r;
            pe  = data[S_PE_LO +: PE_W];
            id  = data[S_TASK_LO +: TASK_W];
            md  = data[S_MOD_LO +: MOD_W];
            cnt = data[S_EXEC_LO +: EXEC_W];
            beats++;
            if (req == REQ_LOAD) begin
                r.kind  = KIND_ACK;
                r.pe    = pe;
                r.stamp = tick_now;
                r.last  = 1'b1;
                if (busy[pe]) begin
                    r.status      = STATUS_REFUSED;
                    r.done_task   = held_id[pe];
                    r.done_module = held_mod[pe];
                    refusals++;
                end else begin
                    busy[pe]       = 1'b1;
                    ticks_left[pe] = cnt;
                    held_id[pe]    = id;
                    held_mod[pe]   = md;
                    r.status       = STATUS_OK;
                    r.done_task    = id;
                    r.done_module  = md;
                    acks++;
                end
                due_results.push_back(r);
            end else begin
                tick_now = tick_now + 1'b1;
                span = int'(active_pes);
                if (span > NPE) span = NPE;
                if (span > MAX_TICK) span = MAX_TICK;
                first = due_results.size();
                for (int i = 0; i < span; i++) begin
                    if (busy[i] && ticks_left[i] != '0) begin
                        ticks_left[i] = ticks_left[i] - 1'b1;
                        if (ticks_left[i] == '0) begin
                            busy[i]       = 1'b0;
                            r.kind        = KIND_DONE;
                            r.status      = STATUS_OK;
                            r.pe          = PE_W'(i);
                            r.done_task   = held_id[i];
                            r.done_module = held_mod[i];
                            r.stamp       = tick_now;
                            r.last        = 1'b0;
                            due_results.push_back(r);
                            completions++;
                        end
                    end
                end
                // tlast goes on the final completion of this tick
                if (due_results.size() > first) begin
                    r = due_results.pop_back();
                    r.last = 1'b1;
                    due_results.push_back(r);
                end
            end
        endfunction

        function void match(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic kind, logic [M_TDATA_W-1:0] data, logic last);
            pool_result_t want;
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: kind %0d, data 0x%0h", kind, data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            match("result_kind", want.kind, kind);
            match("load_status", want.status, data[M_STATUS_LO]);
            match("done_pe", want.pe, data[M_PE_LO +: PE_W]);
            match("done_task", want.done_task, data[M_TASK_LO +: TASK_W]);
            match("done_module", want.done_module, data[M_MOD_LO +: MOD_W]);
            match("time_stamp", want.stamp, data[M_TIME_LO +: TIME_W]);
            match("last_result", want.last, last);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        // ticks needed until every element with a nonzero count has finished
        function int longest_countdown();
            int most;
            most = 0;
            for (int i = 0; i < NPE; i++) begin
                if (busy[i] && int'(ticks_left[i]) > most) most = int'(ticks_left[i]);
            end
            return most;
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;

    logic        quiet        = 1'b0;
    logic        hold_request = 1'b0;
    int unsigned cycle_count  = 0;

    pool_scoreboard pool_sb = new();

    processing_element_pool_countdown_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // inputs only change at rising edges, so mid-cycle values decide each beat
    always @(negedge aclk) begin
        if (aresetn && s_tvalid && s_tready) pool_sb.note_beat(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) pool_sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        logic held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request && !held_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held_off = 1'b1;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 8) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    task automatic send_beat(logic req, logic [PE_W-1:0] pe, logic [TASK_W-1:0] id,
                             logic [MOD_W-1:0] md, logic [EXEC_W-1:0] cnt);
        logic taken;
        if (!quiet && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({cnt, md, id, pe});
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // tick beats carry random filler in the ignored fields
    task automatic tick_beat();
        send_beat(REQ_TICK, PE_W'($urandom), TASK_W'($urandom), MOD_W'($urandom),
                  EXEC_W'($urandom));
    endtask

    task automatic load_beat(logic [PE_W-1:0] pe, logic [TASK_W-1:0] id,
                             logic [MOD_W-1:0] md, logic [EXEC_W-1:0] cnt);
        send_beat(REQ_LOAD, pe, id, md, cnt);
    endtask

    // wait for every expected beat, then let the block finish internal work
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pool_sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_active(logic [CFG_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pool_sb.active_pes = value;
    endtask

    task automatic random_burst(int count);
        logic [EXEC_W-1:0] cnt;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 45) begin
                tick_beat();
            end else begin
                cnt = ($urandom_range(0, 99) < 5) ? EXEC_W'($urandom_range(11, 40))
                                                  : EXEC_W'($urandom_range(1, 10));
                load_beat(PE_W'($urandom_range(0, NPE - 1)), TASK_W'($urandom),
                          MOD_W'($urandom), cnt);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] plan [5];
        plan = '{4'd8, 4'd15, 4'd1, 4'd6, 4'd2};

        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= REQ_TICK;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tick_beat();                                  // nothing loaded yet
        load_beat(3'd0, 16'hFFFF, 8'hFF, 16'd1);
        load_beat(3'd0, 16'h0000, 8'h00, 16'd0);      // busy: reports what it holds
        load_beat(3'd1, 16'h0000, 8'h00, 16'd2);
        load_beat(3'd7, 16'h1234, 8'h5A, 16'd1);
        tick_beat();                                  // elements 0 and 7 finish
        for (int i = 0; i < NPE; i++) begin
            if (i != 1) load_beat(PE_W'(i), TASK_W'($urandom), MOD_W'($urandom), 16'd1);
        end
        tick_beat();                                  // all eight finish on one tick
        write_active(4'd0);
        load_beat(3'd2, 16'h5555, 8'hAA, 16'd1);
        tick_beat();                                  // no element counted down
        write_active(4'd1);
        load_beat(3'd7, 16'hABCD, 8'hC3, 16'd60);     // outside the active range
        tick_beat();
        write_active(4'd3);
        tick_beat();                                  // element 2 now in range

        for (int p = 0; p < 5; p++) begin
            write_active(plan[p]);
            if (p == 1) hold_request = 1'b1;
            random_burst(44);
        end

        // flush every countdown, element 7 included, with no idling
        quiet = 1'b1;
        write_active(4'd15);
        repeat (pool_sb.longest_countdown()) tick_beat();
        load_beat(3'd3, 16'h0F0F, 8'h3C, 16'd0);      // zero count sticks busy for good
        repeat (3) tick_beat();
        load_beat(3'd3, 16'hF0F0, 8'hC3, 16'd4);
        settle();

        $display("run covered %0d input beats: %0d loads taken, %0d refused, %0d completions",
                 pool_sb.beats, pool_sb.acks, pool_sb.refusals, pool_sb.completions);
        $display("active counts 0, 1, 2, 3, 6, 8 and 15, one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (pool_sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
